// ----- rtl/lsbx_pkg.sv -----
// ============================================================================
// lsbx_pkg: shared types and constants for the LSB stego extractor
// Phase codes, queue token layout, status codes and the CRC-32 byte update.
// ============================================================================
package lsbx_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_CRC_ERR = 2'd1;
    localparam logic [1:0] STAT_TOO_BIG = 2'd2;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_CRC,
        PH_LEN,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        TK_HDR,
        TK_DATA,
        TK_OVER
    } tok_kind_t;

    // HDR carries the stored CRC; last set means an empty payload
    typedef struct packed {
        tok_kind_t   kind;
        logic        last;
        logic [31:0] data;
    } tok_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/lsbx_in_if.sv -----
// ============================================================================
// lsbx_in_if: carrier byte channel
// Valid/ready channel carrying one carrier byte and its frame start mark.
// ============================================================================
interface lsbx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] carrier_byte;
    logic       frame_start;

    modport source (output valid, output carrier_byte, output frame_start, input ready);
    modport sink   (input valid, input carrier_byte, input frame_start, output ready);
endinterface

// ----- rtl/lsbx_out_if.sv -----
// ============================================================================
// lsbx_out_if: result channel
// Valid/ready channel carrying one recovered byte and the message status.
// ============================================================================
interface lsbx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output payload_byte, output byte_valid,
                    output last, output status, input ready);
    modport sink   (input valid, input payload_byte, input byte_valid,
                    input last, input status, output ready);
endinterface

// ----- rtl/lsb_stego_extract_check.sv -----
// ============================================================================
// lsb_stego_extract_check: LSB steganography extractor with CRC check
// Recovers a CRC-protected, length-prefixed message from carrier LSBs.
// ============================================================================
// Usage:
//   in_ch  : one carrier byte per request; only bit 0 is used. frame_start
//            restarts extraction with that byte as the first of a new image.
//   out_ch : zero or one result per carrier byte: recovered payload bytes,
//            with last/status on the final one (ok, crc mismatch, too large).
//   cfg    : cfg_we/cfg_index/cfg_data write image_width (0) and
//            image_height (1); write only while the block is idle.
// Throughput: one carrier byte per cycle while the 4-entry token queue has
//   room; the back pops one token per cycle while out_ch is not held.
// Path: a result's token is written into the queue, then popped into the
//   output register that drives out_ch (front -> queue -> output register).
// Capacity w*h*3/8 is a two-stage pipeline off the width/height registers
//   (prod_reg, then cap_reg).
// Reset: width and height return to 1, extraction restarts on the CRC header,
//   queue and output register empty.
// Stall: when out_ch is held, the output register keeps its result, the queue
//   fills, and in_ch.ready drops once the queue is full.
// ============================================================================
module lsb_stego_extract_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lsbx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsbx_pkg::CFG_DATA_W-1:0] cfg_data,
    lsbx_in_if.sink                        in_ch,
    lsbx_out_if.source                     out_ch
);
    import lsbx_pkg::*;

    tok_t push_tok;
    tok_t pop_tok;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    lsbx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .tok       (push_tok)
    );

    lsbx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .pop_tok  (pop_tok),
        .full     (q_full),
        .empty    (q_empty)
    );

    lsbx_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_tok   (pop_tok),
        .q_empty (q_empty),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

// ----- rtl/lsbx_front.sv -----
// ============================================================================
// lsbx_front: bit gathering and header parsing
// Collects carrier LSBs into bytes, parses CRC and length headers, checks
// capacity and pushes one token per payload byte or header outcome.
// ============================================================================
module lsbx_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lsbx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsbx_pkg::CFG_DATA_W-1:0] cfg_data,
    lsbx_in_if.sink                        in_ch,
    input  logic                           q_full,
    output logic                           push,
    output lsbx_pkg::tok_t                 tok
);
    import lsbx_pkg::*;

    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [31:0] prod_reg;
    logic [30:0] cap_reg;
    logic [33:0] prod_x3;

    phase_t      phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [6:0]  acc_reg, acc_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [31:0] scrc_reg, scrc_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] left_reg, left_next;

    phase_t      eff_phase;
    logic [2:0]  eff_idx;
    logic [6:0]  eff_acc;
    logic [1:0]  eff_hcnt;
    logic        accept;
    logic        lsb;
    logic        byte_done;
    logic [7:0]  b;
    logic [31:0] full_len;
    logic        too_big;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign lsb         = in_ch.carrier_byte[0];

    // capacity = w*h*3/8, pipelined off the config registers
    assign prod_x3 = {2'b00, prod_reg} + {1'b0, prod_reg, 1'b0};

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // frame start restarts before the byte is used
    always_comb
    begin
        if (in_ch.frame_start)
        begin
            eff_phase = PH_CRC;
            eff_idx   = 3'd0;
            eff_acc   = 7'd0;
            eff_hcnt  = 2'd0;
        end
        else
        begin
            eff_phase = phase_reg;
            eff_idx   = idx_reg;
            eff_acc   = acc_reg;
            eff_hcnt  = hcnt_reg;
        end
    end

    assign byte_done = (eff_phase != PH_DONE) && (eff_idx == 3'd7);
    assign b         = {lsb, eff_acc};
    assign full_len  = {b, len_reg[31:8]};
    assign too_big   = ({2'b00, cap_reg} < ({1'b0, full_len} + 33'd8));

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        hcnt_next  = hcnt_reg;
        scrc_next  = scrc_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        if (accept)
        begin
            phase_next = eff_phase;
            idx_next   = eff_idx;
            acc_next   = eff_acc;
            hcnt_next  = eff_hcnt;
            if (eff_phase != PH_DONE)
            begin
                if (!byte_done)
                begin
                    acc_next = eff_acc | (7'(lsb) << eff_idx);
                    idx_next = eff_idx + 3'd1;
                end
                else
                begin
                    idx_next = 3'd0;
                    acc_next = 7'd0;
                    unique case (eff_phase)
                        PH_CRC:
                        begin
                            scrc_next = {b, scrc_reg[31:8]};
                            hcnt_next = eff_hcnt + 2'd1;
                            if (eff_hcnt == 2'd3)
                                phase_next = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            len_next  = full_len;
                            hcnt_next = eff_hcnt + 2'd1;
                            if (eff_hcnt == 2'd3)
                            begin
                                if (too_big || (full_len == 32'd0))
                                    phase_next = PH_DONE;
                                else
                                begin
                                    left_next  = full_len;
                                    phase_next = PH_DATA;
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            left_next = left_reg - 32'd1;
                            if (left_reg == 32'd1)
                                phase_next = PH_DONE;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // token output
    always_comb
    begin
        push      = 1'b0;
        tok.kind  = TK_DATA;
        tok.last  = 1'b0;
        tok.data  = {24'd0, b};
        if (accept && byte_done)
        begin
            unique case (eff_phase)
                PH_LEN:
                begin
                    if (eff_hcnt == 2'd3)
                    begin
                        push = 1'b1;
                        if (too_big)
                        begin
                            tok.kind = TK_OVER;
                            tok.last = 1'b1;
                        end
                        else
                        begin
                            tok.kind = TK_HDR;
                            tok.last = (full_len == 32'd0);
                            tok.data = scrc_reg;
                        end
                    end
                end
                PH_DATA:
                begin
                    push     = 1'b1;
                    tok.last = (left_reg == 32'd1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            prod_reg   <= 32'd1;
            cap_reg    <= 31'd0;
            phase_reg  <= PH_CRC;
            idx_reg    <= 3'd0;
            acc_reg    <= 7'd0;
            hcnt_reg   <= 2'd0;
            scrc_reg   <= 32'd0;
            len_reg    <= 32'd0;
            left_reg   <= 32'd0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            prod_reg   <= 32'(width_reg) * 32'(height_reg);
            cap_reg    <= prod_x3[33:3];
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            hcnt_reg   <= hcnt_next;
            scrc_reg   <= scrc_next;
            len_reg    <= len_next;
            left_reg   <= left_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("front pushed into full queue");
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE && !in_ch.frame_start) |-> !push)
        else $error("token pushed after message end");
    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (left_reg != 32'd0))
        else $error("payload phase with no bytes left");
`endif

endmodule

// ----- rtl/lsbx_queue.sv -----
// ============================================================================
// lsbx_queue: token queue between front and back
// Small flop-based FIFO that lets front and back stall independently.
// ============================================================================
module lsbx_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lsbx_pkg::tok_t push_tok,
    input  logic           pop,
    output lsbx_pkg::tok_t pop_tok,
    output logic           full,
    output logic           empty
);
    import lsbx_pkg::*;

    tok_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_tok = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + Q_PTR_W'(1);
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + Q_PTR_W'(1);
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + Q_CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - Q_CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == cnt_reg[Q_PTR_W-1:0])
        else $error("queue pointers disagree with count");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/lsbx_back.sv -----
// ============================================================================
// lsbx_back: CRC engine and result register
// Pops tokens, runs CRC-32 over payload bytes and drives the result channel.
// ============================================================================
module lsbx_back (
    input  logic           clk,
    input  logic           rst_n,
    input  lsbx_pkg::tok_t q_tok,
    input  logic           q_empty,
    output logic           pop,
    lsbx_out_if.source     out_ch
);
    import lsbx_pkg::*;

    logic [31:0] crc_reg, crc_next;
    logic [31:0] scrc_reg, scrc_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        bval_reg, bval_next;
    logic        last_reg, last_next;
    logic [1:0]  stat_reg, stat_next;
    logic [31:0] crc_upd;
    logic        emit;

    assign pop     = !q_empty && (!valid_reg || out_ch.ready);
    assign crc_upd = crc_byte(crc_reg, q_tok.data[7:0]);

    always_comb
    begin
        crc_next  = crc_reg;
        scrc_next = scrc_reg;
        emit      = 1'b0;
        byte_next = byte_reg;
        bval_next = bval_reg;
        last_next = last_reg;
        stat_next = stat_reg;
        if (pop)
        begin
            unique case (q_tok.kind)
                TK_HDR:
                begin
                    crc_next  = CRC_INIT;
                    scrc_next = q_tok.data;
                    emit      = q_tok.last;
                    byte_next = 8'd0;
                    bval_next = 1'b0;
                    last_next = 1'b1;
                    // empty payload: CRC of no data is zero
                    stat_next = (q_tok.data == 32'd0) ? STAT_OK : STAT_CRC_ERR;
                end
                TK_DATA:
                begin
                    crc_next  = crc_upd;
                    emit      = 1'b1;
                    byte_next = q_tok.data[7:0];
                    bval_next = 1'b1;
                    last_next = q_tok.last;
                    if (q_tok.last && ((~crc_upd) != scrc_reg))
                        stat_next = STAT_CRC_ERR;
                    else
                        stat_next = STAT_OK;
                end
                TK_OVER:
                begin
                    emit      = 1'b1;
                    byte_next = 8'd0;
                    bval_next = 1'b0;
                    last_next = 1'b1;
                    stat_next = STAT_TOO_BIG;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (pop)
            valid_next = emit;
        else if (out_ch.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.payload_byte = byte_reg;
    assign out_ch.byte_valid   = bval_reg;
    assign out_ch.last         = last_reg;
    assign out_ch.status       = stat_reg;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        bval_reg <= bval_next;
        last_reg <= last_next;
        stat_reg <= stat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            scrc_reg  <= 32'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            scrc_reg  <= scrc_next;
            valid_reg <= valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && stat_reg != STAT_OK) |-> last_reg)
        else $error("nonzero status on a non-final result");
    a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !bval_reg) |-> last_reg)
        else $error("status-only result not marked last");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ch.ready) |=> (valid_reg && $stable(byte_reg)))
        else $error("stalled result changed");
`endif

endmodule

// ----- tb/sv/lsbx_tb_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lsbx_tb_pkg: result tracking for the LSB stego extractor testbench
// Holds a bit-level model of the extractor that turns each carrier request
// into the results it should cause, and checks the results that come out.
// ============================================================================
package lsbx_tb_pkg;

    import lsbx_pkg::*;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
        logic [1:0] status;
    } extract_result_t;

    // reflected CRC-32, one data bit at a time
    function automatic logic [31:0] crc32_shift_byte(input logic [31:0] crc,
                                                     input logic [7:0]  d);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            c = (c[0] ^ d[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    class extract_scoreboard;
        logic [15:0] img_w;
        logic [15:0] img_h;

        phase_t      ph;
        logic [2:0]  bit_pos;
        logic [7:0]  acc;
        logic [2:0]  hdr_cnt;
        logic [31:0] stored_crc;
        logic [31:0] msg_len;
        logic [31:0] run_crc;
        logic [31:0] left;

        extract_result_t expected_q[$];
        int n_checked;
        int n_last;
        int n_mismatch;

        function new();
            img_w = 16'd1;
            img_h = 16'd1;
            n_checked = 0;
            n_last = 0;
            n_mismatch = 0;
            restart();
        endfunction

        function void restart();
            ph = PH_CRC;
            bit_pos = '0;
            acc = '0;
            hdr_cnt = '0;
            stored_crc = '0;
            msg_len = '0;
            run_crc = CRC_INIT;
            left = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            if (idx == REG_IMAGE_WIDTH)
                img_w = v;
            else if (idx == REG_IMAGE_HEIGHT)
                img_h = v;
        endfunction

        function longint unsigned capacity();
            longint unsigned area;
            area = img_w;
            area = area * img_h;
            return (area * 3) / 8;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [1:0] crc_status();
            return ((~run_crc) == stored_crc) ? STAT_OK : STAT_CRC_ERR;
        endfunction

        function void emit(logic [7:0] b, logic bv, logic lst, logic [1:0] st);
            extract_result_t r;
            r.payload_byte = b;
            r.byte_valid = bv;
            r.last = lst;
            r.status = st;
            expected_q.push_back(r);
        endfunction

        // one accepted carrier request
        function void note_carrier(logic [7:0] cb, logic fs);
            logic [7:0] b;
            if (fs)
                restart();
            if (ph == PH_DONE)
                return;
            acc[bit_pos] = cb[0];
            if (bit_pos != 3'd7)
            begin
                bit_pos++;
                return;
            end
            b = acc;
            bit_pos = '0;
            acc = '0;
            case (ph) inside
                PH_CRC, PH_LEN:
                begin
                    if (ph == PH_CRC)
                        stored_crc[{hdr_cnt[1:0], 3'b000} +: 8] = b;
                    else
                        msg_len[{hdr_cnt[1:0], 3'b000} +: 8] = b;
                    hdr_cnt++;
                    if (hdr_cnt < 3'd4)
                        return;
                    hdr_cnt = '0;
                    if (ph == PH_CRC)
                    begin
                        ph = PH_LEN;
                        return;
                    end
                    if (capacity() < {32'd0, msg_len} + 64'd8)
                    begin
                        ph = PH_DONE;
                        emit(8'h00, 1'b0, 1'b1, STAT_TOO_BIG);
                    end
                    else if (msg_len == '0)
                    begin
                        ph = PH_DONE;
                        emit(8'h00, 1'b0, 1'b1, crc_status());
                    end
                    else
                    begin
                        left = msg_len;
                        ph = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    run_crc = crc32_shift_byte(run_crc, b);
                    left--;
                    if (left == '0)
                    begin
                        ph = PH_DONE;
                        emit(b, 1'b1, 1'b1, crc_status());
                    end
                    else
                        emit(b, 1'b1, 1'b0, STAT_OK);
                end
                default: ;
            endcase
        endfunction

        function void check_result(extract_result_t got);
            extract_result_t want;
            n_checked++;
            if (expected_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: payload %02h byte_valid %0d",
                             got.payload_byte, got.byte_valid,
                             " last %0d status %0d", got.last, got.status);
                return;
            end
            want = expected_q.pop_front();
            if (want.last)
                n_last++;
            if (got.payload_byte !== want.payload_byte || got.byte_valid !== want.byte_valid ||
                got.last !== want.last || got.status !== want.status)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch at result %0d: exp payload %02h bv %0d last %0d st %0d,",
                             n_checked, want.payload_byte, want.byte_valid, want.last,
                             want.status,
                             " got payload %02h bv %0d last %0d st %0d",
                             got.payload_byte, got.byte_valid, got.last, got.status);
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench for lsb_stego_extract_check
// Encodes messages (CRC, length, payload) into carrier LSBs and streams them
// in with random gaps and output stalls; every result is checked against a
// bit-level model. Covers capacity limits, CRC errors, restarts and noise.
// ============================================================================
module tb_top;

    import lsbx_pkg::*;
    import lsbx_tb_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 700;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lsbx_in_if  in_ch();
    lsbx_out_if out_ch();

    lsb_stego_extract_check u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    extract_scoreboard sb = new();

    bit no_gaps   = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int n_carriers = 0;
    int n_frames   = 0;
    int n_configs  = 0;
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        extract_result_t got;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.payload_byte = out_ch.payload_byte;
                got.byte_valid = out_ch.byte_valid;
                got.last = out_ch.last;
                got.status = out_ch.status;
                sb.check_result(got);
            end
            if (hold_req && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 17);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [7:0] carrier_for(input logic lsb, input int fill);
        logic [7:0] r;
        r = 8'($urandom);
        if (fill == 1)
            r = {8{lsb}};
        else if (fill == 2)
            r = {{7{~lsb}}, lsb};
        r[0] = lsb;
        return r;
    endfunction

    task automatic send_carrier(input logic [7:0] cb, input logic fs);
        if (!no_gaps && $urandom_range(0, 99) < 17)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.carrier_byte <= cb;
        in_ch.frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_carrier(cb, fs);
        n_carriers++;
    endtask

    // limit < 0 sends the whole message, otherwise only that many carriers
    task automatic send_frame(input logic [31:0] len, input int npay, input bit crc_good,
                              input int fill, input int limit, input int tail);
        logic [7:0]  msg[$];
        logic [7:0]  body[$];
        logic [7:0]  pay;
        logic [31:0] crc;
        int total;
        int sent;
        crc = CRC_INIT;
        for (int i = 0; i < npay; i++)
        begin
            pay = 8'($urandom);
            body.push_back(pay);
            if (i < len)
                crc = crc32_shift_byte(crc, pay);
        end
        crc = crc_good ? ~crc : (~crc ^ (32'h1 << $urandom_range(0, 31)));
        for (int k = 0; k < 4; k++)
            msg.push_back(crc[8*k +: 8]);
        for (int k = 0; k < 4; k++)
            msg.push_back(len[8*k +: 8]);
        msg = {msg, body};
        total = (limit < 0) ? msg.size() * 8 : limit;
        sent = 0;
        for (int i = 0; i < msg.size() && sent < total; i++)
        begin
            for (int j = 0; j < 8 && sent < total; j++)
            begin
                send_carrier(carrier_for(msg[i][j], fill), sent == 0);
                sent++;
            end
        end
        repeat (tail) send_carrier(8'($urandom), 1'b0);
        n_frames++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_image_size(input logic [15:0] w, input logic [15:0] h);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        sb.write_reg(REG_IMAGE_WIDTH, w);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        sb.write_reg(REG_IMAGE_HEIGHT, h);
        cfg_we <= 1'b0;
        n_configs++;
    endtask

    task automatic random_frame(input bit clean);
        longint unsigned cap;
        logic [31:0] len;
        int kind;
        int npay;
        int fill;
        cap = sb.capacity();
        kind = clean ? 0 : $urandom_range(0, 99);
        fill = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
        if (kind < 60)
        begin
            npay = (cap < 8) ? 0 : $urandom_range(0, (cap - 8 > 12) ? 12 : int'(cap - 8));
            send_frame(npay, npay, $urandom_range(0, 3) != 0, fill, -1, $urandom_range(0, 3));
        end
        else if (kind < 70)
        begin
            // just past the capacity limit
            len = (cap < 8) ? $urandom : 32'(cap - 7 + $urandom_range(0, 3));
            send_frame(len, 0, 1'b1, fill, -1, $urandom_range(0, 3));
        end
        else if (kind < 80)
        begin
            npay = $urandom_range(0, 4);
            send_frame($urandom, npay, 1'b0, fill, $urandom_range(1, 64 + 8 * npay), 0);
        end
        else if (kind < 90)
        begin
            npay = $urandom_range(0, 6);
            send_frame(npay, npay, 1'b1, fill, $urandom_range(1, 64 + 8 * npay), 0);
        end
        else
        begin
            repeat ($urandom_range(1, 20))
                send_carrier(8'($urandom), $urandom_range(0, 9) == 0);
        end
    endtask

    initial
    begin
        longint unsigned cap;
        int rand_target;
        int next_cfg_at;
        int cfg_round;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.carrier_byte <= '0;
        in_ch.frame_start <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size 1x1: nothing fits, not even an empty message
        send_frame(32'd0, 0, 1'b1, 1, -1, 0);
        send_frame(32'hFFFF_FFFF, 0, 1'b1, 2, -1, 9);

        // 8x3 gives room for exactly one payload byte
        set_image_size(16'd8, 16'd3);
        send_frame(32'd0, 0, 1'b1, 0, -1, 2);
        send_frame(32'd0, 0, 1'b0, 0, -1, 0);
        send_frame(32'd1, 1, 1'b1, 0, -1, 3);
        send_frame(32'd1, 1, 1'b0, 1, -1, 0);
        send_frame(32'd2, 2, 1'b1, 0, -1, 0);
        // restart in the middle of a header byte
        send_frame(32'd1, 1, 1'b1, 0, 13, 0);
        send_frame(32'd1, 1, 1'b1, 2, -1, 0);

        set_image_size(16'hFFFF, 16'hFFFF);
        cap = sb.capacity();
        // largest length that fits; cut off after three bytes by the next frame
        send_frame(32'(cap - 8), 3, 1'b1, 0, -1, 0);
        send_frame(32'(cap - 7), 0, 1'b1, 0, -1, 0);
        send_frame(32'hFFFF_FFFF, 0, 1'b1, 1, -1, 0);
        no_gaps = 1'b1;
        send_frame(32'd5, 5, 1'b1, 0, -1, 0);
        send_frame(32'd4, 4, 1'b0, 0, -1, 0);
        no_gaps = 1'b0;
        // long payload while the result side holds off, so in_ch backs up
        hold_req = 1'b1;
        send_frame(32'd24, 24, 1'b1, 0, -1, 0);

        rand_target = n_carriers + RANDOM_ITEMS;
        next_cfg_at = n_carriers;
        cfg_round = 0;
        while (n_carriers < rand_target)
        begin
            if (n_carriers >= next_cfg_at)
            begin
                case (cfg_round)
                    0: set_image_size(16'd1, 16'hFFFF);
                    1: set_image_size(16'hFFFF, 16'd1);
                    default:
                        set_image_size(16'($urandom_range(1, 40)),
                                       16'($urandom_range(0, 1) ? $urandom_range(1, 8)
                                                                : $urandom_range(1, 65535)));
                endcase
                no_gaps = (cfg_round == 3);
                cfg_round++;
                next_cfg_at += RANDOM_ITEMS / 6;
                random_frame(1'b1);
            end
            else
                random_frame(1'b0);
        end
        no_gaps = 1'b0;

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d carrier bytes in %0d frames across %0d image sizes",
                 n_carriers, n_frames, n_configs + 1);
        $display("checked %0d results, %0d message ends, %0d mismatches",
                 sb.n_checked, sb.n_last, sb.n_mismatch);
        if (sb.n_mismatch == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
